@@ src/fat_directory_entry_filter_core_macros.svh @@
// ----------------------------------------------------------------------------
// fat_directory_entry_filter_core_macros
// Assertion shorthands for the FAT directory entry filter.
// ----------------------------------------------------------------------------
`ifndef FAT_DIRECTORY_ENTRY_FILTER_CORE_MACROS_SVH
`define FAT_DIRECTORY_ENTRY_FILTER_CORE_MACROS_SVH

// condition must hold at every clock edge outside reset
`define FDEF_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence must hold in the cycle after the antecedent
`define FDEF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fdef_pkg.sv @@
// ----------------------------------------------------------------------------
// fdef_pkg
// Types and constants shared by the FAT directory entry filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fdef_pkg;

  // record limit per scan
  localparam int unsigned MaxFiles = 256;
  localparam int unsigned CntW     = $clog2(MaxFiles + 1);

  localparam int unsigned EntryBytes = 32;
  localparam int unsigned PosW       = $clog2(EntryBytes);

  // byte offsets inside a 32-byte directory entry
  localparam logic [PosW-1:0] PosExtFirst = PosW'(8);
  localparam logic [PosW-1:0] PosAttr     = PosW'(11);
  localparam logic [PosW-1:0] PosClHiLo   = PosW'(20);
  localparam logic [PosW-1:0] PosClHiHi   = PosW'(21);
  localparam logic [PosW-1:0] PosClLoLo   = PosW'(26);
  localparam logic [PosW-1:0] PosClLoHi   = PosW'(27);
  localparam logic [PosW-1:0] PosSizeLo   = PosW'(28);
  localparam logic [PosW-1:0] PosLast     = PosW'(31);

  localparam logic [7:0] DeletedMark = 8'hE5;
  localparam logic [7:0] EndMark     = 8'h00;

  localparam int unsigned SectorShift = 9;  // 512-byte sectors

  localparam logic [23:0] ExtMatchRst  = 24'h424D50;  // "BMP"
  localparam logic [7:0]  AttrMatchRst = 8'h20;

  localparam int unsigned CfgDataW = 24;

  typedef enum logic [0:0] {
    CfgExtMatch  = 1'b0,
    CfgAttrMatch = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0] ext_match;
    logic [7:0]  attr_match;
  } cfg_t;

  typedef struct packed {
    logic [7:0] entry_byte;
    logic       start_scan;
  } in_item_t;

  typedef struct packed {
    logic        record_valid;
    logic        done_res;
    logic [31:0] start_cluster;
    logic [63:0] short_name;
    logic [23:0] length_sectors;
    logic [7:0]  file_index;
  } out_item_t;

  typedef struct packed {
    logic finished;
  } scan_stat_t;

endpackage

`default_nettype wire

@@ src/fdef_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// fdef_cfg_regs
// Match registers for extension and attribute, written through a plain port.
// ----------------------------------------------------------------------------
`default_nettype none

module fdef_cfg_regs
  import fdef_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire cfg_idx_e            cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgExtMatch:  cfg_d.ext_match  = cfg_data_i[23:0];
        CfgAttrMatch: cfg_d.attr_match = cfg_data_i[7:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ext_match  <= ExtMatchRst;
      cfg_q.attr_match <= AttrMatchRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ src/fdef_entry_scan.sv @@
// ----------------------------------------------------------------------------
// fdef_entry_scan
// Per-byte entry assembly, filter check and record build.
// ----------------------------------------------------------------------------
`default_nettype none

module fdef_entry_scan
  import fdef_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output logic          res_valid_o,
  output out_item_t     res_item_o,
  output scan_stat_t    stat_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            fin_q, fin_d;
  logic [63:0]     name_q, name_d;
  logic [23:0]     ext_q, ext_d;
  logic [7:0]      attr_q, attr_d;
  logic [15:0]     cl_hi_q, cl_hi_d;
  logic [15:0]     cl_lo_q, cl_lo_d;
  logic [31:0]     size_q, size_d;

  logic [PosW-1:0] pos_eff;
  logic [CntW-1:0] cnt_eff;
  logic            fin_eff;
  logic [7:0]      b;
  logic            match;

  always_comb begin
    b       = item_i.entry_byte;
    pos_eff = item_i.start_scan ? '0 : pos_q;
    cnt_eff = item_i.start_scan ? '0 : cnt_q;
    fin_eff = item_i.start_scan ? 1'b0 : fin_q;

    pos_d   = pos_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    name_d  = name_q;
    ext_d   = ext_q;
    attr_d  = attr_q;
    cl_hi_d = cl_hi_q;
    cl_lo_d = cl_lo_q;
    size_d  = size_q;
    match   = 1'b0;

    res_valid_o = 1'b0;
    res_item_o  = '0;

    if (accept_i) begin
      pos_d = pos_eff;
      cnt_d = cnt_eff;
      fin_d = fin_eff;
      if (!fin_eff) begin
        pos_d = pos_eff + PosW'(1);
        if (pos_eff == '0 && b == EndMark) begin
          fin_d                = 1'b1;
          res_valid_o          = 1'b1;
          res_item_o.done_res  = 1'b1;
        end else begin
          priority if (pos_eff < PosExtFirst) begin
            name_d = {name_q[55:0], b};
          end else if (pos_eff < PosAttr) begin
            ext_d = {ext_q[15:0], b};
          end else if (pos_eff == PosAttr) begin
            attr_d = b;
          end else if (pos_eff == PosClHiLo) begin
            cl_hi_d[7:0] = b;
          end else if (pos_eff == PosClHiHi) begin
            cl_hi_d[15:8] = b;
          end else if (pos_eff == PosClLoLo) begin
            cl_lo_d[7:0] = b;
          end else if (pos_eff == PosClLoHi) begin
            cl_lo_d[15:8] = b;
          end else if (pos_eff >= PosSizeLo) begin
            size_d[{pos_eff[1:0], 3'b000} +: 8] = b;
          end else begin
            // reserved bytes of the entry are skipped
            size_d = size_q;
          end

          match = (name_d[63:56] != DeletedMark) &&
                  (attr_d == cfg_i.attr_match) &&
                  (ext_d == cfg_i.ext_match);

          if (pos_eff == PosLast && match) begin
            res_valid_o                = 1'b1;
            res_item_o.record_valid    = 1'b1;
            res_item_o.start_cluster   = {cl_hi_d, cl_lo_d};
            res_item_o.short_name      = name_d;
            res_item_o.length_sectors  = {1'b0, size_d[31:SectorShift]} + 24'd1;
            res_item_o.file_index      = 8'(cnt_eff);
            cnt_d                      = cnt_eff + CntW'(1);
            if (cnt_eff == CntW'(MaxFiles - 1)) begin
              fin_d               = 1'b1;
              res_item_o.done_res = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
      name_q  <= '0;
      ext_q   <= '0;
      attr_q  <= '0;
      cl_hi_q <= '0;
      cl_lo_q <= '0;
      size_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      name_q  <= name_d;
      ext_q   <= ext_d;
      attr_q  <= attr_d;
      cl_hi_q <= cl_hi_d;
      cl_lo_q <= cl_lo_d;
      size_q  <= size_d;
    end
  end

  assign stat_o.finished = fin_q;

endmodule

`default_nettype wire

@@ src/fdef_out_buf.sv @@
// ----------------------------------------------------------------------------
// fdef_out_buf
// Two-slot result buffer; space flag depends only on the fill level.
// ----------------------------------------------------------------------------
`default_nettype none

module fdef_out_buf
  import fdef_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire out_item_t push_item_i,
  output logic           space_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  out_item_t  slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] level_q, level_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (level_q != 2'd0);
  assign space_o     = (level_q != 2'd2);
  assign out_item_o  = slot_q[rd_ptr_q];

  always_comb begin
    level_d = level_q;
    if (push_i && !pop) begin
      level_d = level_q + 2'd1;
    end else if (!push_i && pop) begin
      level_d = level_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      level_q <= level_d;
    end
  end

endmodule

`default_nettype wire

@@ src/fat_directory_entry_filter_core.sv @@
// ----------------------------------------------------------------------------
// fat_directory_entry_filter_core
// Scans a FAT directory byte stream and emits records for matching entries.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------
//  in      | in_valid_i / in_ready_o   | in_item_i  (in_item_t)
//  out     | out_valid_o / out_ready_i | out_item_o (out_item_t)
//  cfg     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One byte per cycle while in_ready_o is high. A result shows on out_valid_o the cycle after the byte
// that completes a matching entry (or hits the end marker) is taken, if the buffer was empty.
// Results sit in a two-slot buffer; in_ready_o drops only when both are full.
// Reset loads the default match values and starts scanning at byte 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fat_directory_entry_filter_core_macros.svh"

module fat_directory_entry_filter_core
  import fdef_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_item_t            in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_item_t                out_item_o,
  input  wire logic                cfg_we_i,
  input  wire cfg_idx_e            cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t       cfg;
  logic       accept;
  logic       res_valid;
  out_item_t  res_item;
  scan_stat_t stat;

  assign accept = in_valid_i && in_ready_o;

  fdef_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  fdef_entry_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_item_o  (res_item),
    .stat_o      (stat)
  );

  fdef_out_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_item_i (res_item),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `FDEF_ASSERT_NEXT(a_done_sets_finished, clk_i, rst_ni, res_valid && res_item.done_res, stat.finished, "done result did not finish the scan")
  `FDEF_ASSERT_NEXT(a_finished_sticky, clk_i, rst_ni, stat.finished && !(accept && in_item_i.start_scan), stat.finished, "scan left finished state without a start")
  `FDEF_ASSERT_NEXT(a_pop_frees_slot, clk_i, rst_ni, out_valid_o && out_ready_i && !in_ready_o, in_ready_o, "buffer stayed full after a result was taken")
  `FDEF_ASSERT_NOW(a_result_kind, clk_i, rst_ni, out_valid_o && !out_item_o.record_valid, out_item_o.done_res, "result carries neither record nor done")

endmodule

`default_nettype wire
